FILE: hdl/cti_pkg.sv
// Shared types and constants for the calibration table interpolator.
`default_nettype none
package cti_pkg;

  // Request codes.
  localparam logic [2:0] FUNC_CLEAR  = 3'd0;
  localparam logic [2:0] FUNC_APPEND = 3'd1;
  localparam logic [2:0] FUNC_S2P    = 3'd2;
  localparam logic [2:0] FUNC_P2S    = 3'd3;
  localparam logic [2:0] FUNC_CHECK  = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BEYOND = 3'd1;
  localparam logic [2:0] ST_FEW    = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_ORDER  = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic eval;      // evaluate the segment whose data has returned
    logic mul;       // start the multiply
    logic div_start; // start the divider
    logic finish;    // form the result
  } cti_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
  } cti_stat_t;

endpackage
`default_nettype wire

FILE: hdl/calibration_table_interpolator_core.sv
// Top level: stream ports, output register, controller and datapath.
// Clear and append go straight to forming the result; check scans the table, one entry
// per cycle; conversions scan the table, then multiply and run the 64-step divider.
// One item is in work at a time; the next is accepted once the result is registered.
// Reset (rst, synchronous, active high) empties the table and the output register;
// table memory contents are left as they are.
`default_nettype none
module calibration_table_interpolator_core
  import cti_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,  // func[2:0], step_word[34:3], length_value[66:35]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [71:0] m_tdata   // status[2:0], step_out[33:3], position_out[65:34]
);
  localparam int AW = $clog2(TABLE_DEPTH);

  cti_cmd_t          cmd;
  cti_stat_t         stat;
  logic [AW-1:0]     rd_idx;
  logic              rd_first, busy, out_set, in_fire, out_free;
  logic [AW:0]       count;
  logic [2:0]        res_status;
  logic [30:0]       res_step;
  logic [31:0]       res_pos;

  assign s_tready = !busy;
  assign in_fire = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  cti_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_func(s_tdata[2:0]),
    .count_in(count), .stat(stat), .out_free(out_free), .busy(busy),
    .out_set(out_set), .cmd(cmd), .rd_idx(rd_idx), .rd_first(rd_first));

  cti_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .rd_idx(rd_idx), .rd_first(rd_first),
    .in_func(s_tdata[2:0]), .in_step(s_tdata[34:3]), .in_len(s_tdata[66:35]),
    .stat(stat), .count_out(count), .res_status(res_status),
    .res_step(res_step), .res_pos(res_pos));

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_set) begin
      m_tvalid <= 1'b1;
      m_tdata <= {6'd0, res_pos, res_step, res_status};
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

FILE: hdl/cti_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module cti_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: hdl/cti_div.sv
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit divisor.
`default_nettype none
module cti_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic      [63:0] quotient,
  output logic      [31:0] remainder
);
  logic [6:0]  count;
  logic        busy;
  logic [32:0] trial;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {remainder, quotient[63]} - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= 7'd64;
        quotient <= dividend;
        remainder <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          remainder <= trial[31:0];
          quotient <= {quotient[62:0], 1'b1};
        end else begin
          remainder <= {remainder[30:0], quotient[63]};
          quotient <= {quotient[62:0], 1'b0};
        end
        count <= count - 7'd1;
        if (count == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: hdl/cti_datapath.sv
// Datapath: table memories, segment search registers, multiplier and divider.
`default_nettype none
module cti_datapath
  import cti_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire cti_cmd_t                       cmd,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0] rd_idx,
  input  wire logic                           rd_first,
  input  wire logic [2:0]                     in_func,
  input  wire logic [31:0]                    in_step,
  input  wire logic [31:0]                    in_len,
  output cti_stat_t                           stat,
  output logic      [$clog2(TABLE_DEPTH):0]   count_out,
  output logic      [2:0]                     res_status,
  output logic      [30:0]                    res_step,
  output logic      [31:0]                    res_pos
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  logic [CW-1:0] entry_count;
  logic [2:0]    func;
  logic [30:0]   s;
  logic [31:0]   v;
  logic [30:0]   sd;
  logic [31:0]   ld;
  logic [30:0]   s_prev, s0;
  logic [31:0]   l_prev, l0;
  logic          found, lerp_up;
  logic          refused;
  logic [31:0]   y0, y1, x0, x1, dy, dx, den;
  logic [63:0]   prod;
  logic [63:0]   quo;
  logic [31:0]   rem;
  logic          div_done;
  logic          we;
  logic [30:0]   s_clamp;

  assign count_out = entry_count;
  assign stat.div_done = div_done;
  assign s_clamp = in_step[31] ? 31'd0 : in_step[30:0];
  assign we = cmd.load && in_func == FUNC_APPEND && entry_count < CW'(TABLE_DEPTH);

  cti_ram #(.WIDTH(31), .DEPTH(TABLE_DEPTH)) u_step_ram (
    .clk(clk), .we(we), .waddr(entry_count[AW-1:0]), .wdata(s_clamp),
    .raddr(rd_idx), .rdata(sd));
  cti_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_len_ram (
    .clk(clk), .we(we), .waddr(entry_count[AW-1:0]), .wdata(in_len),
    .raddr(rd_idx), .rdata(ld));

  // The product of the registered deltas feeds the divider when it starts.
  assign prod = 64'(dy) * 64'(dx);

  cti_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start), .dividend(prod),
    .divisor(den), .done(div_done), .quotient(quo), .remainder(rem));

  // Segment search: each returned entry is compared with the previous one.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      found <= 1'b0;
      refused <= 1'b0;
    end else begin
      if (cmd.load) begin
        func <= in_func;
        s <= s_clamp;
        v <= in_len;
        found <= 1'b0;
        // An append that finds the table full is refused.
        refused <= in_func == FUNC_APPEND && !we;
        if (in_func == FUNC_CLEAR) begin
          entry_count <= '0;
        end else if (we) begin
          entry_count <= entry_count + CW'(1);
        end
      end
      if (cmd.eval) begin
        s_prev <= sd;
        l_prev <= ld;
        if (rd_first) begin
          s0 <= sd;
          l0 <= ld;
        end else if (func == FUNC_CHECK) begin
          if (s > s_prev && s < sd && v > l_prev && v < ld) begin
            found <= 1'b1;
          end
        end else if (func == FUNC_S2P) begin
          if (!found && s >= s_prev && s <= sd) begin
            found <= 1'b1;
            y0 <= l_prev; y1 <= ld; x0 <= {1'b0, s_prev}; x1 <= {1'b0, sd};
          end
        end else begin
          if (v >= l_prev && v <= ld) begin
            found <= 1'b1;
            y0 <= {1'b0, s_prev}; y1 <= {1'b0, sd}; x0 <= l_prev; x1 <= ld;
          end
        end
      end
      // Register the segment deltas.
      if (cmd.mul) begin
        lerp_up <= y1 >= y0;
        dy <= (y1 >= y0) ? y1 - y0 : y0 - y1;
        den <= x1 - x0;
        dx <= ((func == FUNC_S2P) ? {1'b0, s} : v) - x0;
      end
    end
  end

  // Result formation; the final table entry is held in s_prev/l_prev.
  logic [63:0] q_adj;
  logic [31:0] lerp_res;
  assign q_adj = (lerp_up || rem == 32'd0) ? quo : quo + 64'd1;
  assign lerp_res = (den == 32'd0) ? y0 :
                    lerp_up ? y0 + q_adj[31:0] : y0 - q_adj[31:0];

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status <= ST_OK;
      res_step <= '0;
      res_pos <= '0;
      case (func)
        FUNC_APPEND: begin
          if (refused) res_status <= ST_FULL;
        end
        FUNC_CHECK: begin
          if (entry_count == CW'(0)) res_status <= ST_OK;
          else if (entry_count == CW'(TABLE_DEPTH)) res_status <= ST_FULL;
          else if (!found && !(s > s_prev && v > l_prev)) res_status <= ST_ORDER;
        end
        FUNC_S2P: begin
          if (entry_count < CW'(2)) res_status <= ST_FEW;
          else if (s >= s_prev) res_status <= ST_BEYOND;
          else if (s <= s0) res_pos <= '0;
          else if (!found) res_status <= ST_ORDER;
          else res_pos <= lerp_res;
        end
        FUNC_P2S: begin
          if (v == 32'd0) res_step <= '0;
          else if (entry_count < CW'(2)) res_status <= ST_FEW;
          else if (v >= l_prev) res_step <= s_prev;
          else if (v <= l0) res_step <= '0;
          else if (!found) res_status <= ST_ORDER;
          else res_step <= lerp_res[30:0];
        end
        default: begin
          res_status <= ST_OK;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/cti_ctrl.sv
// Controller: sequences the table scan, the multiply and the divide.
`default_nettype none
module cti_ctrl
  import cti_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_fire,
  input  wire logic [2:0]                     in_func,
  input  wire logic [$clog2(TABLE_DEPTH):0]   count_in,
  input  wire cti_stat_t                      stat,
  input  wire logic                           out_free,
  output logic                                busy,
  output logic                                out_set,
  output cti_cmd_t                            cmd,
  output logic      [$clog2(TABLE_DEPTH)-1:0] rd_idx,
  output logic                                rd_first
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_PROD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0]    state;
  logic [CW-1:0] idx;     // next address to read
  logic          pend;    // a read is in flight
  logic [AW-1:0] pend_idx;
  logic          lerp;

  assign busy = state != S_IDLE;
  assign rd_idx = idx[AW-1:0];
  assign rd_first = pend_idx == '0;

  always_comb begin
    cmd = '0;
    cmd.load = in_fire;
    cmd.eval = state == S_SCAN && pend;
    cmd.mul = state == S_MUL;
    cmd.div_start = state == S_PROD;
    cmd.finish = state == S_FIN;
  end

  assign out_set = state == S_OUT && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx <= '0;
      pend <= 1'b0;
      pend_idx <= '0;
      lerp <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            idx <= '0;
            pend <= 1'b0;
            lerp <= in_func == FUNC_S2P || in_func == FUNC_P2S;
            state <= (in_func == FUNC_CLEAR || in_func == FUNC_APPEND) ? S_FIN : S_SCAN;
          end
        end
        // Read entries 0..n-1 one per cycle; the read data comes back registered.
        S_SCAN: begin
          if (idx < count_in) begin
            pend <= 1'b1;
            pend_idx <= idx[AW-1:0];
            idx <= idx + CW'(1);
          end else if (pend) begin
            pend <= 1'b0;
          end else begin
            state <= lerp ? S_MUL : S_FIN;
          end
        end
        S_MUL: state <= S_PROD;
        S_PROD: state <= S_DIV;
        S_DIV: begin
          if (stat.div_done) state <= S_FIN;
        end
        S_FIN: state <= S_OUT;
        S_OUT: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the calibration table interpolator: directed and random requests checked
// against a behavioural predictor.
`default_nettype none
module tb_top;
  import cti_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] steps;
    logic [31:0] position;
  } answer_t;

  typedef longint unsigned u64_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [71:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;

  calibration_table_interpolator_core #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // Predictor copy of the table.
  logic [30:0] cal_steps [DEPTH];
  logic [31:0] cal_lengths [DEPTH];
  int          cal_count;

  answer_t answers_due[$];
  int      failures;
  logic    run_done;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Truncated linear interpolation; the result lies between y0 and y1.
  // The product of the deltas can need all 64 bits, so it is formed unsigned.
  function automatic longint interp(longint y0, longint y1, longint x, longint x0,
                                    longint x1);
    longint den;
    longint dx;
    longint dy;
    u64_t   mag;
    den = x1 - x0;
    dx = x - x0;
    dy = y1 - y0;
    if (den <= 0 || dx < 0) begin
      return y0;
    end
    if (dy >= 0) begin
      mag = u64_t'(dy) * u64_t'(dx);
      return y0 + longint'(mag / u64_t'(den));
    end
    mag = u64_t'(-dy) * u64_t'(dx);
    return y0 - longint'((mag + u64_t'(den) - 1) / u64_t'(den));
  endfunction

  // Works out the answer to one request and updates the table copy.
  function automatic answer_t predict_answer(logic [2:0] func, logic [31:0] word,
                                             logic [31:0] len);
    answer_t     a;
    logic [30:0] s;
    bit          found;
    a = '0;
    s = word[31] ? 31'd0 : word[30:0];
    found = 1'b0;
    case (func)
      FUNC_CLEAR: begin
        cal_count = 0;
      end
      FUNC_APPEND: begin
        if (cal_count >= DEPTH) begin
          a.status = ST_FULL;
        end else begin
          cal_steps[cal_count] = s;
          cal_lengths[cal_count] = len;
          cal_count++;
        end
      end
      FUNC_CHECK: begin
        if (cal_count >= DEPTH) begin
          a.status = ST_FULL;
        end else if (cal_count > 0) begin
          for (int i = 0; i + 1 < cal_count; i++) begin
            if (!found && s > cal_steps[i] && s < cal_steps[i+1] &&
                len > cal_lengths[i] && len < cal_lengths[i+1]) begin
              found = 1'b1;
            end
          end
          if (!found && !(s > cal_steps[cal_count-1] && len > cal_lengths[cal_count-1])) begin
            a.status = ST_ORDER;
          end
        end
      end
      FUNC_S2P: begin
        if (cal_count < 2) begin
          a.status = ST_FEW;
        end else if (s >= cal_steps[cal_count-1]) begin
          a.status = ST_BEYOND;
        end else if (s > cal_steps[0]) begin
          for (int i = 0; i + 1 < cal_count; i++) begin
            if (!found && s >= cal_steps[i] && s <= cal_steps[i+1]) begin
              a.position = 32'(interp(cal_lengths[i], cal_lengths[i+1], s, cal_steps[i],
                                      cal_steps[i+1]));
              found = 1'b1;
            end
          end
          if (!found) begin
            a.status = ST_ORDER;
          end
        end
      end
      FUNC_P2S: begin
        if (len == 0) begin
          a.steps = '0;
        end else if (cal_count < 2) begin
          a.status = ST_FEW;
        end else if (len >= cal_lengths[cal_count-1]) begin
          a.steps = cal_steps[cal_count-1];
        end else if (len > cal_lengths[0]) begin
          // The last matching segment wins.
          for (int i = 0; i + 1 < cal_count; i++) begin
            if (len >= cal_lengths[i] && len <= cal_lengths[i+1]) begin
              a.steps = 31'(interp(cal_steps[i], cal_steps[i+1], len, cal_lengths[i],
                                   cal_lengths[i+1]));
              found = 1'b1;
            end
          end
          if (!found) begin
            a.status = ST_ORDER;
          end
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  // Sends one request after a random gap; valid stays up when the next item follows at once.
  task automatic send_request(logic [2:0] func, logic [31:0] word, logic [31:0] len);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) begin
      gap = 0;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, len, word, func};
    answers_due.push_back(predict_answer(func, word, len));
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Random receiver stalls.
  initial begin
    int stall;
    m_tready = 1'b0;
    forever begin
      stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Compares each result with the oldest expectation.
  always @(posedge clk) begin
    answer_t got;
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tdata[2:0], m_tdata[33:3], m_tdata[65:34]};
      if (answers_due.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        failures++;
      end else begin
        want = answers_due.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          failures++;
        end
        if (got.steps !== want.steps) begin
          $error("step_out: expected %0d, actual %0d", want.steps, got.steps);
          failures++;
        end
        if (got.position !== want.position) begin
          $error("position_out: expected %h, actual %h", want.position, got.position);
          failures++;
        end
      end
    end
  end

  // Builds an ordered table of the given size with random spacing.
  task automatic build_table(int size, int max_step_gap, int max_len_gap);
    logic [31:0] st;
    logic [31:0] ln;
    st = $urandom_range(0, 1000);
    ln = $urandom_range(0, 70000);
    send_request(FUNC_CLEAR, $urandom, $urandom);
    for (int i = 0; i < size; i++) begin
      send_request(FUNC_APPEND, st, ln);
      st += $urandom_range(1, max_step_gap);
      ln += $urandom_range(1, max_len_gap);
    end
  endtask

  task automatic test_directed();
    send_request(FUNC_S2P, 32'd5, 32'd0);
    send_request(FUNC_P2S, 32'd0, 32'd0);
    send_request(FUNC_P2S, 32'd0, 32'd7);
    send_request(FUNC_CHECK, 32'd3, 32'd3);
    send_request(FUNC_APPEND, 32'hFFFF_FFFF, 32'h0001_0000);
    send_request(FUNC_APPEND, 32'd100, 32'h0003_0000);
    send_request(FUNC_APPEND, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(FUNC_S2P, 32'h8000_0000, 32'd0);
    send_request(FUNC_S2P, 32'd50, 32'd0);
    send_request(FUNC_S2P, 32'h7FFF_FFFE, 32'd0);
    send_request(FUNC_S2P, 32'h7FFF_FFFF, 32'd0);
    send_request(FUNC_P2S, 32'd0, 32'h0002_0000);
    send_request(FUNC_P2S, 32'd0, 32'hFFFF_FFFE);
    send_request(FUNC_P2S, 32'd0, 32'hFFFF_FFFF);
    send_request(FUNC_P2S, 32'd0, 32'd1);
    send_request(FUNC_CHECK, 32'd50, 32'h0002_0000);
    send_request(FUNC_CHECK, 32'd50, 32'h0009_0000);
    send_request(3'd5, 32'd1, 32'd1);
    send_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Unordered table with a zero-width segment.
    send_request(FUNC_CLEAR, 32'd0, 32'd0);
    send_request(FUNC_APPEND, 32'd10, 32'd500);
    send_request(FUNC_APPEND, 32'd10, 32'd200);
    send_request(FUNC_APPEND, 32'd30, 32'd900);
    send_request(FUNC_S2P, 32'd20, 32'd0);
    send_request(FUNC_P2S, 32'd0, 32'd300);
  endtask

  task automatic test_full_table();
    build_table(DEPTH, 1 << 20, 1 << 24);
    send_request(FUNC_APPEND, 32'd1, 32'd1);
    send_request(FUNC_CHECK, 32'd1, 32'd1);
    for (int k = 0; k < 8; k++) begin
      send_request(FUNC_S2P, $urandom_range(0, 1 << 24), 32'd0);
      send_request(FUNC_P2S, 32'd0, $urandom);
    end
  endtask

  task automatic test_random();
    logic [2:0] func;
    int         pick;
    for (int r = 0; r < 40; r++) begin
      if ($urandom_range(0, 3) == 0) begin
        build_table($urandom_range(0, DEPTH + 1), 1 << $urandom_range(1, 30),
                    1 << $urandom_range(1, 27));
      end else if ($urandom_range(0, 4) == 0) begin
        // Disordered table from random appends.
        send_request(FUNC_CLEAR, $urandom, $urandom);
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
          send_request(FUNC_APPEND, $urandom_range(0, 60), $urandom_range(0, 60));
        end
      end
      for (int k = 0; k < 14; k++) begin
        pick = $urandom_range(1, 9);
        if (pick > 4) begin
          func = (pick == 9) ? 3'($urandom_range(5, 7)) : 3'(pick - 3);
        end else begin
          func = 3'(pick);
        end
        if (func == FUNC_CHECK && $urandom_range(0, 1) == 1) begin
          send_request(func, $urandom_range(0, 60), $urandom_range(0, 60));
        end else if (func == FUNC_APPEND) begin
          send_request(func, $urandom, $urandom);
        end else if ($urandom_range(0, 3) == 0) begin
          send_request(func, $urandom, $urandom);
        end else begin
          send_request(func, $urandom_range(0, 1 << $urandom_range(1, 30)),
                       $urandom_range(0, 1 << $urandom_range(1, 31)));
        end
      end
      if (r == 20) begin
        wait_drained();
      end
    end
  endtask

  initial begin
    failures = 0;
    run_done = 1'b0;
    cal_count = 0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random();
    wait_drained();
    run_done = 1'b1;
    if (failures == 0) begin
      $display("calibration_table_interpolator_core test passed");
    end else begin
      $display("calibration_table_interpolator_core test failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4ms;
    if (!run_done) begin
      $display("calibration_table_interpolator_core test failed");
      $finish;
    end
  end

endmodule
`default_nettype wire
